### hw/rtl/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;

	localparam int IN_DEPTH_DEF  = 2;
	localparam int OUT_DEPTH_DEF = 2;
	localparam int REG_IDX_W     = 3;
	localparam int REG_DATA_W    = 64;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TEMP_COEFFS  = 3'd0,
		REG_PRESS_LOW    = 3'd1,
		REG_PRESS_HIGH   = 3'd2,
		REG_PRESS_P9_HUM = 3'd3,
		REG_HUM_B        = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [15:0] h4;
		logic [15:0] h5;
		logic [7:0]  h6;
	} coef_t;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} in_t;

	typedef struct packed {
		logic [23:0] temperature;
		logic [16:0] humidity;
		logic        zero;
	} side_t;

	typedef struct packed {
		logic [23:0] temperature;
		logic [31:0] pressure;
		logic [16:0] humidity;
		logic        status;
	} res_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	// 64-bit wrapping product with a 17-bit signed operand, two partial products
	function automatic logic [63:0] mul64s17(input logic [63:0] a, input logic [16:0] b);
		logic signed [49:0] lo;
		logic [31:0] hi;
		lo = $signed({1'b0, a[31:0]}) * $signed(b);
		hi = a[63:32] * {{15{b[16]}}, b};
		return {{14{lo[49]}}, lo} + {hi, 32'b0};
	endfunction

endpackage

### hw/rtl/esc_fifo.sv
`timescale 1ns / 1ps
module esc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == FULLC);
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end
endmodule

### hw/rtl/esc_core.sv
`timescale 1ns / 1ps
module esc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  esc_pkg::in_t   in_word,
	input  esc_pkg::coef_t coef,
	output logic           out_vld,
	output logic [63:0]    out_num,
	output logic [63:0]    out_den,
	output esc_pkg::side_t out_side
);
	import esc_pkg::*;

	logic [15:0] vld_q;

	logic [31:0] d1_s1, d_s1;
	logic [19:0] p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8, p_s9, p_s10;
	logic [15:0] hr_s1, hr_s2, hr_s3, hr_s4, hr_s5, hr_s6;
	logic [31:0] m1_s2, dd_s2;
	logic [31:0] a_s3, q_s3;
	logic [31:0] tfine_s4;
	logic [23:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic [23:0] temp_s11, temp_s12, temp_s13, temp_s14, temp_s15, temp_s16;
	logic [63:0] v1_s5;
	logic [31:0] h_s5;
	logic [63:0] pa_s6, v1p5_s6, v1p2_s6;
	logic [31:0] pb_s6, hm5_s6, hh6_s6, hh3_s6;
	logic [63:0] vv_s7, v1p5_s7, v1p2_s7;
	logic [31:0] x_s7, y0_s7, k_s7;
	logic [63:0] v2a_s8, v1a_s8, v1p5_s8, v1p2_s8;
	logic [31:0] y1_s8, x_s8;
	logic [63:0] v2_s9, v1s_s9;
	logic [31:0] y2_s9, x_s9;
	logic [63:0] w_s10, v2_s10;
	logic [31:0] y3m_s10, x_s10;
	logic [63:0] v1m_s11, num0_s11;
	logic [31:0] y3_s11, x_s11;
	logic [63:0] var1_s12, num_s12;
	logic [31:0] hv_s12;
	logic [31:0] sh_s13, hv_s13;
	logic [63:0] var1_s13, num_s13;
	logic [31:0] ss_s14, hv_s14;
	logic [63:0] var1_s14, num_s14;
	logic [31:0] u_s15, hv_s15;
	logic [63:0] var1_s15, num_s15;
	logic [16:0] hum_s16;
	logic        zero_s16;
	logic [63:0] num_s16, den_s16;

	logic [31:0] temp_c, hf_c, hcl_c;
	logic [63:0] pd_c;

	assign temp_c = asr32((tfine_s4 << 2) + tfine_s4 + 32'd128, 8);
	assign pd_c   = 64'd1048576 - {44'b0, p_s10};
	assign hf_c   = hv_s15 - asr32(u_s15, 4);

	always_comb begin
		if (hf_c[31]) begin
			hcl_c = '0;
		end else if (hf_c > 32'd419430400) begin
			hcl_c = 32'd419430400;
		end else begin
			hcl_c = hf_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[14:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature
			d1_s1    <= {15'b0, in_word.raw_temperature[19:3]} - {15'b0, coef.t1, 1'b0};
			d_s1     <= {16'b0, in_word.raw_temperature[19:4]} - {16'b0, coef.t1};
			p_s1     <= in_word.raw_pressure;
			hr_s1    <= in_word.raw_humidity;
			m1_s2    <= d1_s1 * sx16(coef.t2);
			dd_s2    <= d_s1 * d_s1;
			p_s2     <= p_s1;
			hr_s2    <= hr_s1;
			a_s3     <= asr32(m1_s2, 11);
			q_s3     <= asr32(dd_s2, 12) * sx16(coef.t3);
			p_s3     <= p_s2;
			hr_s3    <= hr_s2;
			tfine_s4 <= a_s3 + asr32(q_s3, 14);
			p_s4     <= p_s3;
			hr_s4    <= hr_s3;
			temp_s5  <= temp_c[23:0];
			v1_s5    <= {{32{tfine_s4[31]}}, tfine_s4} - 64'd128000;
			h_s5     <= tfine_s4 - 32'd76800;
			p_s5     <= p_s4;
			hr_s5    <= hr_s4;
			// pressure and humidity products
			pa_s6    <= {32'b0, v1_s5[31:0]} * {32'b0, v1_s5[31:0]};
			pb_s6    <= v1_s5[63:32] * v1_s5[31:0];
			v1p5_s6  <= mul64s17(v1_s5, {coef.p5[15], coef.p5});
			v1p2_s6  <= mul64s17(v1_s5, {coef.p2[15], coef.p2});
			hm5_s6   <= h_s5 * sx16(coef.h5);
			hh6_s6   <= h_s5 * sx8(coef.h6);
			hh3_s6   <= h_s5 * {24'b0, coef.h3};
			temp_s6  <= temp_s5;
			p_s6     <= p_s5;
			hr_s6    <= hr_s5;
			vv_s7    <= pa_s6 + {pb_s6[30:0], 1'b0, 32'b0};
			v1p5_s7  <= v1p5_s6;
			v1p2_s7  <= v1p2_s6;
			x_s7     <= asr32({2'b0, hr_s6, 14'b0} - {coef.h4[11:0], 20'b0} - hm5_s6
				+ 32'd16384, 15);
			y0_s7    <= asr32(hh6_s6, 10);
			k_s7     <= asr32(hh3_s6, 11) + 32'd32768;
			temp_s7  <= temp_s6;
			p_s7     <= p_s6;
			v2a_s8   <= mul64s17(vv_s7, {coef.p6[15], coef.p6});
			v1a_s8   <= mul64s17(vv_s7, {coef.p3[15], coef.p3});
			v1p5_s8  <= v1p5_s7;
			v1p2_s8  <= v1p2_s7;
			y1_s8    <= y0_s7 * k_s7;
			x_s8     <= x_s7;
			temp_s8  <= temp_s7;
			p_s8     <= p_s7;
			v2_s9    <= v2a_s8 + (v1p5_s8 << 17) + ({{48{coef.p4[15]}}, coef.p4} << 35);
			v1s_s9   <= asr64(v1a_s8, 8) + (v1p2_s8 << 12);
			y2_s9    <= asr32(y1_s8, 10) + 32'd2097152;
			x_s9     <= x_s8;
			temp_s9  <= temp_s8;
			p_s9     <= p_s8;
			w_s10    <= v1s_s9 + 64'h0000_8000_0000_0000;
			v2_s10   <= v2_s9;
			y3m_s10  <= y2_s9 * sx16(coef.h2);
			x_s10    <= x_s9;
			temp_s10 <= temp_s9;
			p_s10    <= p_s9;
			v1m_s11  <= mul64s17(w_s10, {1'b0, coef.p1});
			num0_s11 <= (pd_c << 31) - v2_s10;
			y3_s11   <= asr32(y3m_s10 + 32'd8192, 14);
			x_s11    <= x_s10;
			temp_s11 <= temp_s10;
			var1_s12 <= asr64(v1m_s11, 33);
			num_s12  <= mul64s17(num0_s11, 17'd3125);
			hv_s12   <= x_s11 * y3_s11;
			temp_s12 <= temp_s11;
			sh_s13   <= asr32(hv_s12, 15);
			hv_s13   <= hv_s12;
			var1_s13 <= var1_s12;
			num_s13  <= num_s12;
			temp_s13 <= temp_s12;
			ss_s14   <= sh_s13 * sh_s13;
			hv_s14   <= hv_s13;
			var1_s14 <= var1_s13;
			num_s14  <= num_s13;
			temp_s14 <= temp_s13;
			u_s15    <= asr32(ss_s14, 7) * {24'b0, coef.h1};
			hv_s15   <= hv_s14;
			var1_s15 <= var1_s14;
			num_s15  <= num_s14;
			temp_s15 <= temp_s14;
			hum_s16  <= hcl_c[28:12];
			zero_s16 <= (var1_s15 == '0);
			num_s16  <= num_s15;
			den_s16  <= var1_s15;
			temp_s16 <= temp_s15;
		end
	end

	assign out_vld              = vld_q[15];
	assign out_num              = num_s16;
	assign out_den              = den_s16;
	assign out_side.temperature = temp_s16;
	assign out_side.humidity    = hum_s16;
	assign out_side.zero        = zero_s16;
endmodule

### hw/rtl/esc_div.sv
`timescale 1ns / 1ps
module esc_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [63:0]    num,
	input  logic [63:0]    den,
	input  esc_pkg::side_t in_side,
	output logic           out_vld,
	output logic [63:0]    quot,
	output esc_pkg::side_t out_side
);
	import esc_pkg::*;

	localparam int N = 64;

	logic [N:0]  vld_q;
	logic [63:0] rem_q [N+1];
	logic [63:0] nq_q  [N+1];
	logic [63:0] dv_q  [N+1];
	logic        neg_q [N+1];
	side_t       side_q [N+1];
	logic        ovld_q;
	logic [63:0] quot_q;
	side_t       oside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			ovld_q <= 1'b0;
		end else if (en) begin
			vld_q  <= {vld_q[N-1:0], in_vld};
			ovld_q <= vld_q[N];
		end
	end

	// magnitudes and quotient sign
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= '0;
			nq_q[0]   <= num[63] ? (~num + 64'd1) : num;
			dv_q[0]   <= den[63] ? (~den + 64'd1) : den;
			neg_q[0]  <= num[63] ^ den[63];
			side_q[0] <= in_side;
		end
	end

	// one quotient bit per stage
	for (genvar i = 1; i <= N; i++) begin : g_stage
		logic [64:0] t;
		logic [64:0] df;
		logic        ge;
		assign t  = {rem_q[i-1], nq_q[i-1][63]};
		assign df = t - {1'b0, dv_q[i-1]};
		assign ge = (t >= {1'b0, dv_q[i-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= ge ? df[63:0] : t[63:0];
				nq_q[i]   <= {nq_q[i-1][62:0], ge};
				dv_q[i]   <= dv_q[i-1];
				neg_q[i]  <= neg_q[i-1];
				side_q[i] <= side_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_q  <= neg_q[N] ? (~nq_q[N] + 64'd1) : nq_q[N];
			oside_q <= side_q[N];
		end
	end

	assign out_vld  = ovld_q;
	assign quot     = quot_q;
	assign out_side = oside_q;
endmodule

### hw/rtl/esc_post.sv
`timescale 1ns / 1ps
module esc_post (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [63:0]    quot,
	input  esc_pkg::side_t in_side,
	input  esc_pkg::coef_t coef,
	output logic           out_vld,
	output esc_pkg::res_t  out_word
);
	import esc_pkg::*;

	logic [5:0]  vld_q;
	logic [63:0] q_s1, q_s2, q_s3, q_s4;
	logic [63:0] ps_s1, ps_s2;
	logic [63:0] t_s2, p8p_s2, p8p_s3, p8p_s4;
	logic [63:0] pa_s3;
	logic [31:0] pb_s3, pc_s3;
	logic [63:0] t2_s4;
	logic [63:0] sum_s5;
	side_t       sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	res_t        word_s6;
	logic [63:0] pf_c;
	logic [31:0] sat_c;

	assign pf_c = asr64(sum_s5, 8) + ({{48{coef.p7[15]}}, coef.p7} << 4);

	always_comb begin
		if (pf_c[63]) begin
			sat_c = '0;
		end else if (pf_c[63:32] != '0) begin
			sat_c = '1;
		end else begin
			sat_c = pf_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s1  <= asr64(quot, 13);
			q_s1   <= quot;
			sd_s1  <= in_side;
			t_s2   <= mul64s17(ps_s1, {coef.p9[15], coef.p9});
			p8p_s2 <= mul64s17(q_s1, {coef.p8[15], coef.p8});
			ps_s2  <= ps_s1;
			q_s2   <= q_s1;
			sd_s2  <= sd_s1;
			pa_s3  <= {32'b0, t_s2[31:0]} * {32'b0, ps_s2[31:0]};
			pb_s3  <= t_s2[31:0] * ps_s2[63:32];
			pc_s3  <= t_s2[63:32] * ps_s2[31:0];
			p8p_s3 <= p8p_s2;
			q_s3   <= q_s2;
			sd_s3  <= sd_s2;
			t2_s4  <= pa_s3 + {pb_s3 + pc_s3, 32'b0};
			p8p_s4 <= p8p_s3;
			q_s4   <= q_s3;
			sd_s4  <= sd_s3;
			sum_s5 <= q_s4 + asr64(t2_s4, 25) + asr64(p8p_s4, 19);
			sd_s5  <= sd_s4;
			word_s6.temperature <= sd_s5.temperature;
			word_s6.pressure    <= sd_s5.zero ? '0 : sat_c;
			word_s6.humidity    <= sd_s5.zero ? '0 : sd_s5.humidity;
			word_s6.status      <= sd_s5.zero;
		end
	end

	assign out_vld  = vld_q[5];
	assign out_word = word_s6;
endmodule

### hw/rtl/env_sensor_compensation.sv
`timescale 1ns / 1ps
// Compensation of one raw pressure/temperature/humidity sample per word.
// Input side is a queue: drive the raw fields with push while full is low.
// Output side is a queue: a word is on the result ports while empty is low
// and leaves on pop. Calibration words are written through wr_en/wr_index/
// wr_data; the user must write them only while no sample is in flight, as the
// block does not enforce it. Indexes past the last register are dropped.
// Path from push to empty going low: the input queue, the compensation front,
// whose first stage reads the input queue directly, the pipelined 64-bit
// divider (one quotient bit per stage), the pressure back end and the output
// queue.
// Throughput: one word per cycle while the pipeline is not frozen; every stage,
// including the divider, takes a new word each cycle when not frozen.
// When pop is held low the result queue fills, the whole pipeline freezes in
// place once its last stage holds a word, full rises once the input queue
// fills, and nothing is dropped. Reset clears the queues, the pipeline valid
// bits and all calibration registers to zero.
module env_sensor_compensation #(
	parameter int IN_DEPTH  = esc_pkg::IN_DEPTH_DEF,
	parameter int OUT_DEPTH = esc_pkg::OUT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [19:0]                    raw_pressure,
	input  logic [19:0]                    raw_temperature,
	input  logic [15:0]                    raw_humidity,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [23:0]             temperature,
	output logic [31:0]                    pressure,
	output logic [16:0]                    humidity,
	output logic                           status,
	input  logic                           wr_en,
	input  logic [esc_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [esc_pkg::REG_DATA_W-1:0] wr_data
);
	import esc_pkg::*;

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_low_q, press_high_q;
	logic [47:0] p9_hum_q;
	logic [39:0] hum_b_q;
	coef_t       coef;

	in_t   in_word, fr_word;
	logic  fr_empty, en, fr_pop;
	logic  core_vld, div_vld, post_vld;
	logic [63:0] core_num, core_den, quot;
	side_t core_side, div_side;
	res_t  post_word, out_word;
	logic  ofull;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_low_q   <= '0;
			press_high_q  <= '0;
			p9_hum_q      <= '0;
			hum_b_q       <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_TEMP_COEFFS:  temp_coeffs_q <= wr_data[47:0];
				REG_PRESS_LOW:    press_low_q   <= wr_data;
				REG_PRESS_HIGH:   press_high_q  <= wr_data;
				REG_PRESS_P9_HUM: p9_hum_q      <= wr_data[47:0];
				REG_HUM_B:        hum_b_q       <= wr_data[39:0];
				default: ;
			endcase
		end
	end

	assign coef.t1 = temp_coeffs_q[15:0];
	assign coef.t2 = temp_coeffs_q[31:16];
	assign coef.t3 = temp_coeffs_q[47:32];
	assign coef.p1 = press_low_q[15:0];
	assign coef.p2 = press_low_q[31:16];
	assign coef.p3 = press_low_q[47:32];
	assign coef.p4 = press_low_q[63:48];
	assign coef.p5 = press_high_q[15:0];
	assign coef.p6 = press_high_q[31:16];
	assign coef.p7 = press_high_q[47:32];
	assign coef.p8 = press_high_q[63:48];
	assign coef.p9 = p9_hum_q[15:0];
	assign coef.h1 = p9_hum_q[23:16];
	assign coef.h2 = p9_hum_q[39:24];
	assign coef.h3 = p9_hum_q[47:40];
	assign coef.h4 = hum_b_q[15:0];
	assign coef.h5 = hum_b_q[31:16];
	assign coef.h6 = hum_b_q[39:32];

	assign in_word.raw_pressure    = raw_pressure;
	assign in_word.raw_temperature = raw_temperature;
	assign in_word.raw_humidity    = raw_humidity;

	// pipeline advances unless the last stage holds a word the output queue cannot take
	assign en     = !(post_vld && ofull);
	assign fr_pop = en && !fr_empty;

	esc_fifo #(
		.W     ($bits(in_t)),
		.DEPTH (IN_DEPTH)
	) u_in_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (in_word),
		.full  (full),
		.rd    (fr_pop),
		.rdata (fr_word),
		.empty (fr_empty)
	);

	esc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (fr_pop),
		.in_word (fr_word),
		.coef    (coef),
		.out_vld (core_vld),
		.out_num (core_num),
		.out_den (core_den),
		.out_side(core_side)
	);

	esc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (core_vld),
		.num     (core_num),
		.den     (core_den),
		.in_side (core_side),
		.out_vld (div_vld),
		.quot    (quot),
		.out_side(div_side)
	);

	esc_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (div_vld),
		.quot    (quot),
		.in_side (div_side),
		.coef    (coef),
		.out_vld (post_vld),
		.out_word(post_word)
	);

	esc_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (post_vld),
		.wdata (post_word),
		.full  (ofull),
		.rd    (pop),
		.rdata (out_word),
		.empty (empty)
	);

	assign temperature = out_word.temperature;
	assign pressure    = out_word.pressure;
	assign humidity    = out_word.humidity;
	assign status      = out_word.status;
endmodule
